### design/assert_macros.svh
// Assertion macros for the filter RTL.
// Depends on nothing; files that check their logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### design/tmsf_pkg.sv
// Constants, types and the control/status structs of the trimmed-mean filter.
// Used by tmsf_rank and trimmed_mean_sample_filter_top; depends on nothing.
package tmsf_pkg;

   localparam int WINDOW      = 16;
   localparam int TRIM_LOW    = 4;
   localparam int TRIM_HIGH   = 11;
   localparam int SAMPLE_BITS = 16;

   localparam int DATA_W = 16;
   localparam int IDX_W  = $clog2(WINDOW);

   // Upper rank clamped to the window, and the count of kept ranks
   localparam int TRIM_HI_CLAMP = (TRIM_HIGH > WINDOW - 1) ? WINDOW - 1 : TRIM_HIGH;
   localparam bit TRIM_EMPTY    = (TRIM_LOW > TRIM_HI_CLAMP);
   localparam int TRIM_COUNT    = TRIM_EMPTY ? 1 : TRIM_HI_CLAMP - TRIM_LOW + 1;
   localparam int SUM_W         = DATA_W + IDX_W + 1;

   typedef logic [DATA_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [SUM_W-1:0]  sum_type;

   localparam sample_type SAMPLE_MASK = DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam idx_type    IDX_LAST    = IDX_W'(WINDOW - 1);

   // Control from the top level into the ranking engine
   typedef struct packed {
      logic start;     // last sample of a window written this beat
      logic out_free;  // result register can load this cycle
   } rank_ctl_type;

   // Status from the ranking engine back to the top level
   typedef struct packed {
      logic       idle;    // engine free; window memory may be written
      logic       done;    // result valid and taken this cycle
      sample_type result;  // trimmed mean of the ranked window
   } rank_sts_type;

endpackage

### design/tmsf_rank.sv
// Window memory and ranking engine of the trimmed-mean filter.
// Depends on tmsf_pkg; ranks each entry by a full scan of the memory.
module tmsf_rank (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  tmsf_pkg::idx_type     wr_addr,
   input  tmsf_pkg::sample_type  wr_data,
   input  tmsf_pkg::rank_ctl_type ctl,
   output tmsf_pkg::rank_sts_type sts
);
   import tmsf_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_FETCH, S_HOLD, S_SCAN, S_DONE} state_type;

   state_type  state_ff;
   idx_type    i_ff;
   idx_type    j_ff;
   idx_type    count_ff;
   sample_type pivot_ff;
   sum_type    sum_ff;
   sample_type rd_data_ff;
   sample_type mem [WINDOW];

   idx_type    rd_addr;
   logic       less_now;
   idx_type    rank_now;
   logic       keep_now;

   // Pick the read address: pivot, first entry, or next scanned entry
   always_comb begin
      unique case (state_ff)
         S_FETCH: rd_addr = i_ff;
         S_SCAN:  rd_addr = j_ff + idx_type'(1);
         default: rd_addr = '0;
      endcase
   end

   // Window memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Stable rank: smaller entries, plus equal entries that came earlier
   assign less_now = (rd_data_ff < pivot_ff) || ((rd_data_ff == pivot_ff) && (j_ff < i_ff));
   assign rank_now = count_ff + idx_type'(less_now);
   assign keep_now = (int'(rank_now) >= TRIM_LOW) && (int'(rank_now) <= TRIM_HI_CLAMP);

   // Sequence the scan: one pivot per outer pass, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (ctl.start) begin
                  i_ff     <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               state_ff <= S_HOLD;
            end
            S_HOLD: begin
               pivot_ff <= rd_data_ff;
               j_ff     <= '0;
               count_ff <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (j_ff == IDX_LAST) begin
                  if (keep_now) begin
                     sum_ff <= sum_ff + SUM_W'(pivot_ff);
                  end
                  if (i_ff == IDX_LAST) begin
                     state_ff <= S_DONE;
                  end else begin
                     i_ff     <= i_ff + idx_type'(1);
                     state_ff <= S_FETCH;
                  end
               end else begin
                  count_ff <= rank_now;
                  j_ff     <= j_ff + idx_type'(1);
               end
            end
            S_DONE: begin
               if (ctl.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Report status and the truncated mean of the kept ranks
   always_comb begin
      sts.idle   = (state_ff == S_IDLE);
      sts.done   = (state_ff == S_DONE) && ctl.out_free;
      sts.result = TRIM_EMPTY ? '0 : DATA_W'(sum_ff / SUM_W'(TRIM_COUNT));
   end

endmodule

### design/trimmed_mean_sample_filter_top.sv
// Trimmed-mean sample filter. Each sample beat is written into a 16-entry
// window memory. The sixteenth sample of a window starts the ranking engine,
// which scans the whole memory through its single read port once for each
// entry, then hands the result to the output register. No sample is taken
// during that scan or until the result is handed over. The result register
// lets the next window start filling while a result still waits on
// rsp_tready. Windows do not overlap; no result comes before a window is
// full.
// Depends on tmsf_pkg, tmsf_rank and assert_macros.svh.
`include "assert_macros.svh"

module trimmed_mean_sample_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] filtered_value
);
   import tmsf_pkg::*;

   idx_type      fill_ff;
   idx_type      fill_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   sample_type   rsp_data_ff;
   logic         req_beat;
   rank_ctl_type ctl;
   rank_sts_type sts;

   // Take samples only while the engine does not read the window
   assign req_tready = sts.idle;
   assign req_beat   = req_tvalid && req_tready;

   assign ctl.start    = req_beat && (fill_ff == IDX_LAST);
   assign ctl.out_free = !rsp_valid_ff || rsp_tready;

   tmsf_rank u_rank (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_beat),
      .wr_addr (fill_ff),
      .wr_data (req_tdata & SAMPLE_MASK),
      .ctl     (ctl),
      .sts     (sts)
   );

   // Advance the fill position, wrap after the last slot
   always_comb begin
      fill_in = fill_ff;
      if (req_beat) begin
         fill_in = (fill_ff == IDX_LAST) ? '0 : fill_ff + idx_type'(1);
      end
   end

   // Load the result register when the engine finishes, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (sts.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sts.done) begin
         rsp_data_ff <= sts.result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A window completes only with the fill position back at slot zero
   `ASSERT_CLK(a_done_fill_zero, sts.done |-> (fill_ff == '0), "ranking ended mid-window")
   // The last sample of a window must take the engine out of idle
   `ASSERT_CLK(a_start_busy, ctl.start |=> !sts.idle, "engine did not start on a full window")
   // A result appears only after the engine hands one over
   `ASSERT_CLK(a_rsp_from_done, $rose(rsp_tvalid) |-> $past(sts.done), "result without ranking")
   // The engine never finishes into an occupied, stalled result register
   `ASSERT_NEVER(a_no_overwrite, sts.done && rsp_valid_ff && !rsp_tready, "result overwritten")

endmodule

### test/tb.sv
// Self-checking bench for trimmed_mean_sample_filter_top: streams ADC samples,
// predicts the trimmed mean of each completed window and checks every result.
// Depends on tmsf_pkg and the filter RTL only.
module tb;
   import tmsf_pkg::*;

   // Predicts window results and checks the result beats in order
   class trimmed_mean_scoreboard;
      sample_type  window_copy[WINDOW];
      int unsigned fill_slot;
      sample_type  expected_means[$];
      int unsigned mismatches;

      function new();
         fill_slot  = 0;
         mismatches = 0;
      endfunction

      // Rank a copy of the window and average the kept ranks
      function sample_type window_mean();
         sample_type      ranked[WINDOW];
         sample_type      v;
         int              j;
         int              lo;
         int              hi;
         longint unsigned sum;
         lo = TRIM_LOW;
         hi = (TRIM_HIGH > WINDOW - 1) ? WINDOW - 1 : TRIM_HIGH;
         // An empty rank range yields zero
         if (lo > hi) begin
            return '0;
         end
         for (int i = 0; i < WINDOW; i++) begin
            v = window_copy[i];
            j = i;
            while (j > 0 && ranked[j-1] > v) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = v;
         end
         sum = 0;
         for (int i = lo; i <= hi; i++) begin
            sum += ranked[i];
         end
         return sample_type'(sum / longint'(hi - lo + 1));
      endfunction

      // Store one accepted sample; a full window queues its expected mean
      function void note_sample(logic [15:0] raw);
         longint unsigned keep_mask;
         keep_mask = (64'd1 << SAMPLE_BITS) - 64'd1;
         if (fill_slot >= WINDOW) begin
            fill_slot = 0;
         end
         window_copy[fill_slot] = sample_type'(raw & keep_mask);
         fill_slot++;
         if (fill_slot >= WINDOW) begin
            fill_slot = 0;
            expected_means.push_back(window_mean());
         end
      endfunction

      // Compare one result beat with the oldest expected mean
      function void check_result(logic [15:0] actual);
         sample_type want;
         if (expected_means.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: filtered_value %h", actual);
            end
            return;
         end
         want = expected_means.pop_front();
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("filtered_value: expected %h, actual %h", want, actual);
            end
         end
      endfunction

      function bit clean();
         return mismatches == 0 && expected_means.size() == 0;
      endfunction
   endclass

   typedef enum {MIX_WIDE, MIX_CLUSTER, MIX_REPEAT, MIX_EXTREME} mix_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] sample_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] filtered_value

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   trimmed_mean_scoreboard scoreboard = new();

   trimmed_mean_sample_filter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watch both channels for beats
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         scoreboard.note_sample(req_tdata);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         scoreboard.check_result(rsp_tdata);
      end
   end

   // Offer one sample, idling first at random; hold valid until taken
   task automatic send_sample(input logic [15:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Send one window of random samples in the given mix
   task automatic send_random_window(input mix_kind_type mix);
      logic [15:0] base;
      logic [15:0] value;
      base = 16'($urandom);
      for (int i = 0; i < WINDOW; i++) begin
         case (mix)
            MIX_WIDE: begin
               value = 16'($urandom);
            end
            MIX_CLUSTER: begin
               value = base + 16'($urandom_range(31));
            end
            MIX_REPEAT: begin
               value = ($urandom_range(3) != 0) ? base : 16'($urandom);
            end
            default: begin
               case ($urandom_range(3))
                  0: value = 16'h0000;
                  1: value = 16'hFFFF;
                  2: value = 16'h0001;
                  default: value = 16'hFFFE;
               endcase
            end
         endcase
         send_sample(value);
      end
   endtask

   logic [15:0] corner_samples[16] = '{
      16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF,
      16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1234, 16'h0000, 16'hFFFF, 16'h8001
   };

   initial begin
      int drain_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 27;
               recv_idle_pct = 76;
            end
            1: begin
               send_idle_pct = 76;
               recv_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // Directed windows: mixed corner values, then all maximum
         if (phase == 0) begin
            foreach (corner_samples[i]) begin
               send_sample(corner_samples[i]);
            end
            for (int i = 0; i < WINDOW; i++) begin
               send_sample(16'hFFFF);
            end
         end
         for (int w = 0; w < 10; w++) begin
            send_random_window(mix_kind_type'($urandom_range(3)));
         end
      end
      req_tvalid <= 1'b0;

      // Drain outstanding results, then watch for strays
      drain_cycles = 0;
      while (scoreboard.expected_means.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (400) @(posedge clock);
      if (scoreboard.clean()) begin
         $display("trimmed_mean_sample_filter_top: match");
      end else begin
         $display("trimmed_mean_sample_filter_top: mismatch");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #3000000;
      $display("trimmed_mean_sample_filter_top: mismatch");
      $finish;
   end

endmodule
